// File: hw/rtl/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
// no dependencies; used by the top level, the output buffer and the testbench
package hcbp_pkg;

  localparam int MAX_CODE_LEN = 16;
  localparam int SYMBOL_COUNT = 256;

  localparam int BYTE_BITS  = 8;
  localparam int CODE_W     = 16;
  localparam int LEN_W      = 5;
  localparam int SYM_W      = 8;
  localparam int CMD_W      = 2;
  localparam int SYM_AW     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ENTRY_W    = CODE_W + LEN_W;
  localparam int LEN_CAP    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int ACC_W      = BYTE_BITS - 1;
  localparam int CNT_W      = 3;
  localparam int WIDE_W     = CODE_W + ACC_W;
  localparam int TOT_W      = 5;
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_AW    = 2;
  localparam int OBUF_CW    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] packed_byte;
    logic                 final_byte;
  } out_beat_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  // up to two result bytes handed to the output buffer in one cycle
  typedef struct packed {
    logic [1:0] n;
    out_beat_t  beat0;
    out_beat_t  beat1;
  } push_t;

endpackage

// File: hw/rtl/huffman_code_bit_packer.sv
// huffman code bit packer top level: code table ram, packing stage, output buffer
// depends on hcbp_pkg, hcbp_ram, hcbp_out_buf
//
//   channel | signals                       | beat
//   --------+-------------------------------+----------------------------------
//   input   | in_valid, in_ready, in_data   | load entry, encode byte or flush
//   output  | out_valid, out_ready, out_data| one packed byte, final flag
//
// a beat is taken every cycle while the output buffer has two free slots; the
// table read data is registered, packing works on it and its bytes are written
// into the output buffer. the output port drains one byte a cycle while
// out_ready is high, so codes that complete two bytes are held by the output.
// reset clears the accumulator, the pending count and the buffer, not the table.
// in_ready depends only on internal state, never on out_ready.
module huffman_code_bit_packer import hcbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic               in_acc;
  logic               in_range;
  logic [LEN_W-1:0]   sat_len;
  logic [CODE_W-1:0]  code_mask;
  entry_t             wr_entry;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_entry;

  logic               s1_valid;
  logic [CMD_W-1:0]   s1_cmd;
  logic               s1_in_range;
  logic               s1_adv;
  logic               room;

  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [WIDE_W-1:0]  wide;
  logic [TOT_W-1:0]   total;
  logic [ACC_W-1:0]   acc_mask;
  push_t              push;

  assign in_acc   = in_valid && in_ready;
  assign in_range = {1'b0, in_data.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);

  // saturate the length and drop code bits above it before storing
  always_comb begin
    sat_len = (in_data.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_data.code_length;
    for (int i = 0; i < CODE_W; i++) begin
      code_mask[i] = LEN_W'(i) < sat_len;
    end
    wr_entry.len  = sat_len;
    wr_entry.code = in_data.code_bits & code_mask;
  end

  hcbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (in_acc && in_data.command == CMD_LOAD && in_range),
    .waddr(in_data.symbol[SYM_AW-1:0]),
    .wdata(wr_entry),
    .re   (in_acc),
    .raddr(in_data.symbol[SYM_AW-1:0]),
    .rdata(rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  assign s1_adv   = s1_valid && room;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd      <= in_data.command;
      s1_in_range <= in_range;
    end
  end

  // packing: pending bits above the new code, bytes cut from the top
  always_comb begin
    wide  = (WIDE_W'(acc) << rd_entry.len) | WIDE_W'(rd_entry.code);
    total = TOT_W'(cnt) + rd_entry.len;
    for (int i = 0; i < ACC_W; i++) begin
      acc_mask[i] = CNT_W'(i) < total[CNT_W-1:0];
    end
  end

  always_comb begin
    acc_next   = acc;
    cnt_next   = cnt;
    push.n     = 2'd0;
    push.beat0 = '0;
    push.beat1 = '0;
    case (s1_cmd)
      CMD_ENCODE: begin
        if (s1_in_range) begin
          push.beat0.packed_byte = BYTE_BITS'(wide >> (total - TOT_W'(BYTE_BITS)));
          push.beat1.packed_byte = BYTE_BITS'(wide >> (total - TOT_W'(2 * BYTE_BITS)));
          if (total >= TOT_W'(2 * BYTE_BITS)) begin
            push.n = 2'd2;
          end else if (total >= TOT_W'(BYTE_BITS)) begin
            push.n = 2'd1;
          end
          acc_next = ACC_W'(wide) & acc_mask;
          cnt_next = total[CNT_W-1:0];
        end
      end
      CMD_FLUSH: begin
        push.beat0.packed_byte = BYTE_BITS'({1'b0, acc} << (4'(BYTE_BITS) - {1'b0, cnt}));
        push.beat0.final_byte  = 1'b1;
        if (cnt != '0) begin
          push.n = 2'd1;
        end
        acc_next = '0;
        cnt_next = '0;
      end
      default: begin
      end
    endcase
    if (!s1_adv) begin
      push.n   = 2'd0;
      acc_next = acc;
      cnt_next = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  hcbp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: hw/rtl/hcbp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/hcbp_out_buf.sv
// output byte buffer: takes up to two bytes a cycle, gives one a cycle while out_ready is high
// depends on hcbp_pkg
module hcbp_out_buf import hcbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  out_beat_t          mem [OBUF_DEPTH];
  logic [OBUF_AW-1:0] wr_ptr;
  logic [OBUF_AW-1:0] rd_ptr;
  logic [OBUF_CW-1:0] count;
  logic               pop;

  // two free slots needed so a full two-byte beat always fits
  assign room      = count <= OBUF_CW'(OBUF_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OBUF_AW'(push.n);
      rd_ptr <= rd_ptr + OBUF_AW'(pop);
      count  <= count + OBUF_CW'(push.n) - OBUF_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.beat0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + OBUF_AW'(1)] <= push.beat1;
    end
  end

endmodule

// File: test/huffman_code_bit_packer_test.sv
// testbench for huffman_code_bit_packer: code table loads, encodes and flushes
// checked beat by beat against a behavioural predictor of the packer
// depends on hcbp_pkg and the huffman_code_bit_packer rtl
module huffman_code_bit_packer_test;
  import hcbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  huffman_code_bit_packer u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [CODE_W-1:0] code_tbl [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_tbl  [SYMBOL_COUNT];
  bit                loaded   [SYMBOL_COUNT];
  logic [ACC_W-1:0]  pend_bits = '0;
  logic [CNT_W-1:0]  pend_cnt = '0;
  out_beat_t         byte_q [$];

  int errors = 0;
  int burst_left = 0;

  // receiver stall pattern
  int ready_mode = 0;
  int mode_left = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(3, 20);
        end
      endcase
    end
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
  end

  // output checker
  out_beat_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (byte_q.size() == 0) begin
        $display("%0t: output beat with none expected, actual byte %h final %b",
                 $time, out_data.packed_byte, out_data.final_byte);
        errors++;
      end else begin
        want = byte_q.pop_front();
        if (out_data.packed_byte !== want.packed_byte) begin
          $display("%0t: packed_byte expected %h actual %h",
                   $time, want.packed_byte, out_data.packed_byte);
          errors++;
        end
        if (out_data.final_byte !== want.final_byte) begin
          $display("%0t: final_byte expected %b actual %b",
                   $time, want.final_byte, out_data.final_byte);
          errors++;
        end
      end
    end
  end

  // work out the bytes one accepted beat produces
  task automatic pack_predict(input in_beat_t b);
    logic [LEN_W-1:0] len;
    logic [31:0]      wide;
    logic [31:0]      total;
    int               n;
    case (b.command)
      CMD_LOAD: begin
        if (b.symbol < SYMBOL_COUNT) begin
          len = (b.code_length > LEN_CAP) ? LEN_W'(LEN_CAP) : b.code_length;
          code_tbl[b.symbol] = b.code_bits & CODE_W'((32'd1 << len) - 1);
          len_tbl[b.symbol] = len;
          loaded[b.symbol] = 1'b1;
        end
      end
      CMD_ENCODE: begin
        if (b.symbol < SYMBOL_COUNT) begin
          len = len_tbl[b.symbol];
          wide = (32'(pend_bits) << len) | 32'(code_tbl[b.symbol]);
          total = 32'(pend_cnt) + 32'(len);
          n = 0;
          while (total >= BYTE_BITS && n < 2) begin
            total -= BYTE_BITS;
            byte_q.push_back('{packed_byte: 8'(wide >> total), final_byte: 1'b0});
            n++;
          end
          pend_bits = ACC_W'(wide & ((32'd1 << total) - 1));
          pend_cnt = CNT_W'(total);
        end
      end
      CMD_FLUSH: begin
        if (pend_cnt != 0)
          byte_q.push_back('{packed_byte: 8'({1'b0, pend_bits} << (BYTE_BITS - pend_cnt)),
                             final_byte: 1'b1});
        pend_bits = '0;
        pend_cnt = '0;
      end
      default: ;
    endcase
  endtask

  // drive one beat, with bursts and random gaps, and predict once it is taken
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    int       gap;
    in_beat_t b;
    b = '{command: cmd, symbol: sym, code_bits: code, code_length: len};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pack_predict(b);
  endtask

  // mostly real code lengths, now and then zero or over the cap
  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return LEN_W'($urandom_range(17, 31));
    return LEN_W'($urandom_range(1, 16));
  endfunction

  task automatic test_directed_cases();
    send_beat(CMD_LOAD, 8'd0, 16'hffff, 5'd16);
    send_beat(CMD_LOAD, 8'd255, 16'h0001, 5'd1);
    send_beat(CMD_LOAD, 8'd1, 16'hffff, 5'd0);          // zero length code
    send_beat(CMD_LOAD, 8'd2, 16'($urandom), 5'd31);   // length over the cap
    send_beat(CMD_LOAD, 8'd3, 16'hffff, 5'd5);          // bits above length dropped
    send_beat(CMD_LOAD, 8'd128, 16'h0000, 5'd16);
    send_beat(CMD_LOAD, 8'd127, 16'h0005, 5'd3);
    send_beat(CMD_ENCODE, 8'd255, 16'hffff, 5'd31);
    send_beat(CMD_ENCODE, 8'd0, 16'h0000, 5'd0);        // two bytes from one beat
    send_beat(CMD_ENCODE, 8'd1, 16'h0000, 5'd0);
    send_beat(CMD_ENCODE, 8'd2, 16'h5a5a, 5'd7);
    send_beat(CMD_ENCODE, 8'd3, 16'ha5a5, 5'd24);
    send_beat(CMD_FLUSH, 8'd255, 16'hffff, 5'd31);
    send_beat(CMD_FLUSH, 8'd0, 16'h0000, 5'd0);         // nothing pending
    send_beat(CMD_NONE, 8'($urandom), 16'($urandom), 5'($urandom));
    send_beat(CMD_ENCODE, 8'd127, 16'h0000, 5'd0);
    send_beat(CMD_ENCODE, 8'd127, 16'h0000, 5'd0);
    send_beat(CMD_ENCODE, 8'd127, 16'h0000, 5'd0);
    send_beat(CMD_FLUSH, 8'd0, 16'h0000, 5'd0);
    // encode straight after a load of the same entry
    send_beat(CMD_LOAD, 8'd4, 16'h00a5, 5'd8);
    send_beat(CMD_ENCODE, 8'd4, 16'h0000, 5'd0);
    send_beat(CMD_LOAD, 8'd4, 16'h1234, 5'd16);
    send_beat(CMD_ENCODE, 8'd4, 16'h0000, 5'd0);
    send_beat(CMD_ENCODE, 8'd128, 16'h0000, 5'd0);
    send_beat(CMD_FLUSH, 8'd0, 16'h0000, 5'd0);
  endtask

  task automatic test_table_load();
    for (int s = 0; s < SYMBOL_COUNT; s++)
      send_beat(CMD_LOAD, SYM_W'(s), CODE_W'($urandom), pick_len());
  endtask

  task automatic test_random_stream(input int count);
    int               r;
    logic [SYM_W-1:0] sym;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        do sym = SYM_W'($urandom_range(0, SYMBOL_COUNT - 1)); while (!loaded[sym]);
        send_beat(CMD_ENCODE, sym, CODE_W'($urandom), LEN_W'($urandom));
      end else if (r < 88) begin
        send_beat(CMD_LOAD, SYM_W'($urandom), CODE_W'($urandom), pick_len());
      end else if (r < 96) begin
        send_beat(CMD_FLUSH, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      end else begin
        send_beat(CMD_NONE, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_table_load();
    test_random_stream(450);
    in_valid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("huffman_code_bit_packer_test: done, clean");
    else
      $display("huffman_code_bit_packer_test: done, errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("huffman_code_bit_packer_test: done, errors");
    $finish;
  end

endmodule
